/* rtl/dce_pkg.sv */
// ----------------------------------------------------------------------------
// dce_pkg
// Types and constants shared by the delta command encoder modules.
// ----------------------------------------------------------------------------
package dce_pkg;

    // Command codes on the op field
    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_ADD_HDR  = 3'd1;
    localparam logic [2:0] OP_ADD_DATA = 3'd2;
    localparam logic [2:0] OP_COPY     = 3'd3;
    localparam logic [2:0] OP_END      = 3'd4;

    // Fixed stream bytes
    localparam logic [7:0] BYTE_START = 8'd1;
    localparam logic [7:0] BYTE_END   = 8'd0;
    localparam logic [7:0] CHUNK_MAX  = 8'd248;

    // Copy opcodes: offset bytes / length bytes
    localparam logic [7:0] OPC_O2_L1 = 8'd249;
    localparam logic [7:0] OPC_O2_L2 = 8'd250;
    localparam logic [7:0] OPC_O2_L4 = 8'd251;
    localparam logic [7:0] OPC_O4_L1 = 8'd252;
    localparam logic [7:0] OPC_O4_L2 = 8'd253;
    localparam logic [7:0] OPC_O4_L4 = 8'd254;
    localparam logic [7:0] OPC_O8_L4 = 8'd255;

    localparam int OFFSET_WIDTH_DEF = 32;

    // Longest byte sequence of one command: opcode, 8 offset, 4 length
    localparam int SEQ_BYTES = 13;
    localparam int SEQ_W     = SEQ_BYTES * 8;
    localparam int SEQ_CW    = $clog2(SEQ_BYTES + 1);

    // Command queue between front and back
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] ref_offset;
        logic [31:0] run_length;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_ONE  = 2'd0,
        KIND_TWO  = 2'd1,
        KIND_COPY = 2'd2
    } t_kind;

    // One classified command: one or two plain bytes, or a copy
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [32:0] rel;
        logic [31:0] len;
    } t_cmd;

endpackage

/* rtl/delta_command_encoder_core.sv */
// ----------------------------------------------------------------------------
// delta_command_encoder_core
// Serializes start, add, copy and end commands into delta stream bytes.
//
//   channel   dir  handshake         payload
//   command   in   push / full       i_cmd  (op, ref_offset, run_length,
//                                            data_byte)
//   byte      out  empty / pop       o_byte (out_byte, last)
//
// A command is classified in the cycle it is accepted and queued (4 deep).
// The serializer sends one byte per cycle while pop is high and a byte is
// waiting: a data byte emits one byte, a data byte opening a chunk two, a
// copy 4 to 13, start and end one. Commands that emit nothing never reach
// the serializer. Synchronous active-low reset clears the add/copy state and
// empties the queue and the output. full rises only while the queue is full.
// ----------------------------------------------------------------------------
module delta_command_encoder_core import dce_pkg::*; #(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_cmd,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_byte
);

    logic accept;
    logic fr_valid;
    t_cmd fr_cmd;
    logic q_empty;
    t_cmd q_cmd;
    logic bk_take;

    assign accept = push && !full;

    dce_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_cmd),
        .o_cmd_valid (fr_valid),
        .o_cmd       (fr_cmd)
    );

    dce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fr_valid),
        .i_cmd   (fr_cmd),
        .o_full  (full),
        .i_rd    (bk_take),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    dce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_empty),
        .i_cmd       (q_cmd),
        .o_cmd_take  (bk_take),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_byte)
    );

endmodule

/* rtl/dce_front.sv */
// ----------------------------------------------------------------------------
// dce_front
// Accepts input commands, tracks add and copy state, and emits classified
// commands toward the command queue.
// ----------------------------------------------------------------------------
module dce_front import dce_pkg::*; #(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd
);

    localparam int          OW       = (OFFSET_WIDTH < 32) ? OFFSET_WIDTH : 32;
    localparam logic [32:0] OFF_LIM  = 33'd1 << OW;
    localparam logic [31:0] OFF_MASK = 32'(OFF_LIM - 33'd1);

    logic [31:0] r_prev_off, n_prev_off;
    logic [31:0] r_add_rem,  n_add_rem;
    logic [7:0]  r_chunk,    n_chunk;

    logic [31:0] cur_off;
    logic [7:0]  clen;

    assign cur_off = i_item.ref_offset & OFF_MASK;
    assign clen    = (r_add_rem < 32'(CHUNK_MAX)) ? r_add_rem[7:0] : CHUNK_MAX;

    always_comb begin
        n_prev_off  = r_prev_off;
        n_add_rem   = r_add_rem;
        n_chunk     = r_chunk;
        o_cmd_valid = 1'b0;
        o_cmd.kind  = KIND_ONE;
        o_cmd.b0    = i_item.data_byte;
        o_cmd.b1    = i_item.data_byte;
        o_cmd.rel   = {1'b0, cur_off} - {1'b0, r_prev_off};
        o_cmd.len   = i_item.run_length;
        if (i_accept) begin
            unique case (i_item.op)
                OP_START: begin
                    n_prev_off  = '0;
                    n_add_rem   = '0;
                    n_chunk     = '0;
                    o_cmd_valid = 1'b1;
                    o_cmd.b0    = BYTE_START;
                end
                OP_ADD_HDR: begin
                    n_add_rem = i_item.run_length;
                    n_chunk   = '0;
                end
                OP_ADD_DATA: begin
                    // drop bytes beyond the declared add length
                    if (r_add_rem != '0) begin
                        o_cmd_valid = 1'b1;
                        n_add_rem   = r_add_rem - 32'd1;
                        if (r_chunk == '0) begin
                            o_cmd.kind = KIND_TWO;
                            o_cmd.b0   = clen;
                            n_chunk    = clen - 8'd1;
                        end else begin
                            n_chunk = r_chunk - 8'd1;
                        end
                    end
                end
                OP_COPY: begin
                    o_cmd_valid = 1'b1;
                    o_cmd.kind  = KIND_COPY;
                    n_prev_off  = cur_off;
                    n_add_rem   = '0;
                    n_chunk     = '0;
                end
                OP_END: begin
                    o_cmd_valid = 1'b1;
                    o_cmd.b0    = BYTE_END;
                    n_add_rem   = '0;
                    n_chunk     = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_off <= '0;
            r_add_rem  <= '0;
            r_chunk    <= '0;
        end else begin
            r_prev_off <= n_prev_off;
            r_add_rem  <= n_add_rem;
            r_chunk    <= n_chunk;
        end
    end

endmodule

/* rtl/dce_queue.sv */
// ----------------------------------------------------------------------------
// dce_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dce_queue import dce_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_rd,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd             r_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CQ_CW-1:0] r_count;

    logic do_wr, do_rd;

    assign o_full  = (r_count == CQ_CW'(CQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + CQ_AW'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + CQ_AW'(1);
            end
            r_count <= r_count + CQ_CW'(do_wr) - CQ_CW'(do_rd);
        end
    end

endmodule

/* rtl/dce_back.sv */
// ----------------------------------------------------------------------------
// dce_back
// Expands one queued command into its byte sequence and shifts the bytes
// out one byte at a time.
// ----------------------------------------------------------------------------
module dce_back import dce_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_take,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    logic [SEQ_W-1:0]  r_seq, n_seq;
    logic [SEQ_CW-1:0] r_cnt, n_cnt;

    logic [SEQ_W-1:0]  ld_seq;
    logic [SEQ_CW-1:0] ld_cnt;
    logic              fit16, fit32, len1, len2;
    logic [63:0]       rel64;
    logic [31:0]       len;

    assign rel64 = {{31{i_cmd.rel[32]}}, i_cmd.rel};
    assign len   = i_cmd.len;
    assign fit16 = (i_cmd.rel[32:15] == '0) || (i_cmd.rel[32:15] == '1);
    assign fit32 = (i_cmd.rel[32:31] == 2'b00) || (i_cmd.rel[32:31] == 2'b11);
    assign len1  = (len[31:8] == '0);
    assign len2  = (len[31:16] == '0);

    // build the left-justified byte sequence of the head command
    always_comb begin
        ld_seq = '0;
        ld_cnt = SEQ_CW'(1);
        unique case (i_cmd.kind)
            KIND_ONE: begin
                ld_seq = {i_cmd.b0, {(SEQ_W-8){1'b0}}};
                ld_cnt = SEQ_CW'(1);
            end
            KIND_TWO: begin
                ld_seq = {i_cmd.b0, i_cmd.b1, {(SEQ_W-16){1'b0}}};
                ld_cnt = SEQ_CW'(2);
            end
            KIND_COPY: begin
                priority if (fit16 && len1) begin
                    ld_seq = {OPC_O2_L1, rel64[15:0], len[7:0], {(SEQ_W-32){1'b0}}};
                    ld_cnt = SEQ_CW'(4);
                end else if (fit16 && len2) begin
                    ld_seq = {OPC_O2_L2, rel64[15:0], len[15:0], {(SEQ_W-40){1'b0}}};
                    ld_cnt = SEQ_CW'(5);
                end else if (fit16) begin
                    ld_seq = {OPC_O2_L4, rel64[15:0], len, {(SEQ_W-56){1'b0}}};
                    ld_cnt = SEQ_CW'(7);
                end else if (fit32 && len1) begin
                    ld_seq = {OPC_O4_L1, rel64[31:0], len[7:0], {(SEQ_W-48){1'b0}}};
                    ld_cnt = SEQ_CW'(6);
                end else if (fit32 && len2) begin
                    ld_seq = {OPC_O4_L2, rel64[31:0], len[15:0], {(SEQ_W-56){1'b0}}};
                    ld_cnt = SEQ_CW'(7);
                end else if (fit32) begin
                    ld_seq = {OPC_O4_L4, rel64[31:0], len, {(SEQ_W-72){1'b0}}};
                    ld_cnt = SEQ_CW'(9);
                end else begin
                    ld_seq = {OPC_O8_L4, rel64, len};
                    ld_cnt = SEQ_CW'(13);
                end
            end
            default: begin
                ld_seq = '0;
                ld_cnt = SEQ_CW'(1);
            end
        endcase
    end

    assign empty           = (r_cnt == '0);
    assign o_item.out_byte = r_seq[SEQ_W-1 -: 8];
    assign o_item.last     = (r_cnt == SEQ_CW'(1));

    // reload when the last word leaves or when idle, so commands run back to back
    assign o_cmd_take = i_cmd_valid && (empty || (o_item.last && pop));

    always_comb begin
        n_seq = r_seq;
        n_cnt = r_cnt;
        if (o_cmd_take) begin
            n_seq = ld_seq;
            n_cnt = ld_cnt;
        end else if (pop && !empty) begin
            n_seq = {r_seq[SEQ_W-9:0], 8'h00};
            n_cnt = r_cnt - SEQ_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq <= n_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

/* tb/sv/delta_command_encoder_core_tb.sv */
// ----------------------------------------------------------------------------
// delta_command_encoder_core_tb
// Drives start, add, copy and end commands into the encoder and checks every
// stream byte against typed bytes or a cycle-free software encoder kept in the bench. A short
// table of directed commands comes first, then random command sequences with
// random stalls on both the command and the byte side.
// ----------------------------------------------------------------------------
module delta_command_encoder_core_tb import dce_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Reserved op codes, ignored by the block
    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    localparam longint S16_MIN = -64'sd32768;
    localparam longint S16_MAX = 64'sd32767;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint S32_MAX = 64'sd2147483647;

    localparam int N_DIR      = 25;
    localparam int RAND_ITEMS = 150;
    localparam int CALM_ITEMS = 30;

    typedef struct {
        t_in_item    c;
        int          tn;   // typed expected bytes, -1: use the encoder model
        logic [31:0] tv;   // typed bytes, most significant first
    } t_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  cmd_in  = '0;
    logic      full;
    logic      empty;
    t_out_item byte_out;

    // Encoder model state
    logic [31:0] last_copy_off = '0;
    logic [31:0] lit_left      = '0;
    logic [7:0]  chunk_cnt     = '0;

    t_out_item stream_q[$];
    t_out_item exp_byte;

    bit calm = 1'b0;
    int pop_hold = 0;
    int n_err = 0;
    int n_sent = 0;
    int n_useful = 0;
    int n_bytes = 0;
    int n_chunks = 0;
    int opc_hits [7] = '{default: 0};

    t_row dir_rows [N_DIR] = '{
        '{'{OP_COPY,     32'h0000_0000, 32'h0000_0000, 8'h00}, 4, 32'hF900_0000},
        '{'{OP_START,    32'h0000_0000, 32'h0000_0000, 8'h00}, 1, 32'h0000_0001},
        '{'{OP_END,      32'h0000_0000, 32'h0000_0000, 8'h00}, 1, 32'h0000_0000},
        '{'{OP_ADD_HDR,  32'h0000_0000, 32'h0000_0000, 8'h00}, 0, 32'h0},
        '{'{OP_ADD_DATA, 32'h0000_0000, 32'h0000_0000, 8'hAA}, 0, 32'h0},
        '{'{OP_ADD_HDR,  32'h0000_0000, 32'h0000_0003, 8'h00}, 0, 32'h0},
        '{'{OP_ADD_DATA, 32'h0000_0000, 32'h0000_0000, 8'h00}, 2, 32'h0000_0300},
        '{'{OP_ADD_DATA, 32'h0000_0000, 32'h0000_0000, 8'hFF}, 1, 32'h0000_00FF},
        '{'{OP_ADD_DATA, 32'h0000_0000, 32'h0000_0000, 8'h5A}, -1, 32'h0},
        '{'{OP_ADD_DATA, 32'h0000_0000, 32'h0000_0000, 8'h11}, 0, 32'h0},
        '{'{OP_ADD_HDR,  32'h0000_0000, 32'hFFFF_FFFF, 8'h00}, 0, 32'h0},
        '{'{OP_ADD_DATA, 32'h0000_0000, 32'h0000_0000, 8'h80}, 2, 32'h0000_F880},
        '{'{OP_COPY,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00}, -1, 32'h0},
        '{'{OP_ADD_DATA, 32'h0000_0000, 32'h0000_0000, 8'h33}, 0, 32'h0},
        '{'{OP_COPY,     32'h0000_0000, 32'h0000_0100, 8'h00}, -1, 32'h0},
        '{'{OP_COPY,     32'h0000_7FFF, 32'h0000_00FF, 8'h00}, -1, 32'h0},
        '{'{OP_COPY,     32'h0000_0000, 32'h0000_FFFF, 8'h00}, -1, 32'h0},
        '{'{OP_COPY,     32'h0000_8000, 32'h0001_0000, 8'h00}, -1, 32'h0},
        '{'{OP_COPY,     32'h8000_7FFF, 32'h0000_0001, 8'h00}, -1, 32'h0},
        '{'{OP_COPY,     32'h8000_0000, 32'h0000_012C, 8'h00}, -1, 32'h0},
        '{'{OP_COPY,     32'h0000_0000, 32'h0001_0000, 8'h00}, -1, 32'h0},
        '{'{OP_COPY,     32'h0001_8000, 32'h0000_01FF, 8'h00}, -1, 32'h0},
        '{'{OP_COPY,     32'h0001_0000, 32'h0000_0000, 8'h00}, -1, 32'h0},
        '{'{OP_RSVD_HI,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF}, 0, 32'h0},
        '{'{OP_RSVD_LO,  32'h0000_0000, 32'h0000_0000, 8'h00}, 0, 32'h0}
    };

    delta_command_encoder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_cmd   (cmd_in),
        .empty   (empty),
        .pop     (pop),
        .o_byte  (byte_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic void put_byte(ref t_out_item q[$], input logic [7:0] b);
        t_out_item r;
        r.out_byte = b;
        r.last     = 1'b0;
        q.push_back(r);
    endfunction

    function automatic void put_be(ref t_out_item q[$], input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            put_byte(q, v[8*i +: 8]);
        end
    endfunction

    // Bytes one command adds to the stream; updates the model state
    function automatic void encode_cmd(input t_in_item c, ref t_out_item res[$]);
        logic [63:0] rel;
        longint      srel;
        int          ob;
        int          lb;
        logic [7:0]  opc;
        t_out_item   r;
        case (c.op)
            OP_START: begin
                last_copy_off = '0;
                lit_left      = '0;
                chunk_cnt     = '0;
                put_byte(res, BYTE_START);
            end
            OP_ADD_HDR: begin
                lit_left  = c.run_length;
                chunk_cnt = '0;
            end
            OP_ADD_DATA: begin
                if (lit_left != 0) begin
                    // open a new chunk with its length word
                    if (chunk_cnt == 0) begin
                        chunk_cnt = (lit_left < 32'(CHUNK_MAX)) ? lit_left[7:0] : CHUNK_MAX;
                        put_byte(res, chunk_cnt);
                        n_chunks++;
                    end
                    put_byte(res, c.data_byte);
                    chunk_cnt--;
                    lit_left--;
                end
            end
            OP_COPY: begin
                rel  = {32'd0, c.ref_offset} - {32'd0, last_copy_off};
                srel = $signed(rel);
                if (srel >= S16_MIN && srel <= S16_MAX) ob = 2;
                else if (srel >= S32_MIN && srel <= S32_MAX) ob = 4;
                else ob = 8;
                if (c.run_length <= 32'hFF) lb = 1;
                else if (c.run_length <= 32'hFFFF) lb = 2;
                else lb = 4;
                if (ob == 8) begin
                    opc = OPC_O8_L4;
                    lb  = 4;
                end else if (ob == 2) begin
                    opc = (lb == 1) ? OPC_O2_L1 : (lb == 2) ? OPC_O2_L2 : OPC_O2_L4;
                end else begin
                    opc = (lb == 1) ? OPC_O4_L1 : (lb == 2) ? OPC_O4_L2 : OPC_O4_L4;
                end
                put_byte(res, opc);
                put_be(res, rel, ob);
                put_be(res, {32'd0, c.run_length}, lb);
                opc_hits[opc - OPC_O2_L1]++;
                last_copy_off = c.ref_offset;
                lit_left      = '0;
                chunk_cnt     = '0;
            end
            OP_END: begin
                lit_left  = '0;
                chunk_cnt = '0;
                put_byte(res, BYTE_END);
            end
            default: ;
        endcase
        if (res.size() != 0) begin
            r      = res.pop_back();
            r.last = 1'b1;
            res.push_back(r);
        end
    endfunction

    function automatic t_in_item rand_cmd(input logic [2:0] op);
        t_in_item c;
        c.op         = op;
        c.ref_offset = $urandom;
        c.run_length = $urandom;
        c.data_byte  = 8'($urandom);
        return c;
    endfunction

    // Present one command word and hold it until accepted
    task automatic send_cmd(input t_in_item c, input int tn, input logic [31:0] tv);
        t_out_item res[$];
        t_out_item r;
        if (!calm && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        push   <= 1'b1;
        cmd_in <= c;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        encode_cmd(c, res);
        if (res.size() != 0 || c.op == OP_ADD_HDR) n_useful++;
        if (tn >= 0) begin
            res.delete();
            for (int i = 0; i < tn; i++) begin
                r.out_byte = tv[8*(tn-1-i) +: 8];
                r.last     = (i == tn - 1);
                res.push_back(r);
            end
        end
        foreach (res[i]) stream_q.push_back(res[i]);
        n_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (stream_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_add(input bit long_run);
        t_in_item c;
        int       nb;
        c = rand_cmd(OP_ADD_HDR);
        if (long_run) c.run_length = $urandom_range(249, 300);
        else begin
            case ($urandom_range(0, 9))
                0:       c.run_length = $urandom;
                1:       c.run_length = $urandom_range(240, 260);
                default: c.run_length = $urandom_range(0, 12);
            endcase
        end
        send_cmd(c, -1, '0);
        if (long_run) nb = int'(c.run_length);
        else begin
            nb = (c.run_length > 12) ? $urandom_range(1, 12) : int'(c.run_length);
            case ($urandom_range(0, 7))
                0: nb += $urandom_range(1, 3);               // overrun the declared length
                1: if (nb > 0) nb = $urandom_range(0, nb - 1); // cut the run short
                default: ;
            endcase
        end
        for (int i = 0; i < nb; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_cmd(rand_cmd(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI))), -1, '0);
            send_cmd(rand_cmd(OP_ADD_DATA), -1, '0);
        end
    endtask

    task automatic send_copy();
        t_in_item    c;
        logic [31:0] d;
        c = rand_cmd(OP_COPY);
        case ($urandom_range(0, 4))
            0: d = 32'($urandom_range(0, 65535)) - 32'd32768;
            1: begin
                d = $urandom_range(32768, 32'h7FFF_FFFF);
                if ($urandom_range(0, 1) == 1) d = -d;
            end
            2: d = $urandom;
            3: d = $urandom_range(0, 1) ? 32'h0000_7FFF + 32'($urandom_range(0, 1))
                                         : 32'hFFFF_8000 - 32'($urandom_range(0, 1));
            default: d = 32'h8000_0000 + 32'($urandom_range(0, 1));
        endcase
        c.ref_offset = last_copy_off + d;
        case ($urandom_range(0, 4))
            0: c.run_length = $urandom_range(0, 255);
            1: c.run_length = $urandom_range(256, 65535);
            2: c.run_length = $urandom;
            3: c.run_length = $urandom_range(0, 1) ? 32'h0000_00FF : 32'h0000_0100;
            default: c.run_length = $urandom_range(0, 1) ? 32'h0000_FFFF : 32'h0001_0000;
        endcase
        send_cmd(c, -1, '0);
    endtask

    // Byte side: random stall bursts, none near the end
    always @(posedge i_clk) begin
        if (pop_hold != 0) begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            pop_hold <= $urandom_range(0, 17);
            pop      <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            n_bytes++;
            if (stream_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("[%0t] unexpected byte: out_byte=%02h last=%0b",
                             $realtime, byte_out.out_byte, byte_out.last);
            end else begin
                exp_byte = stream_q.pop_front();
                if (byte_out.out_byte !== exp_byte.out_byte || byte_out.last !== exp_byte.last)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("[%0t] mismatch: out_byte exp %02h got %02h, last exp %0b got %0b",
                                 $realtime, exp_byte.out_byte, byte_out.out_byte,
                                 exp_byte.last, byte_out.last);
                end
            end
        end
    end

    initial begin
        bit  paused;
        int  pick;
        paused = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            send_cmd(dir_rows[i].c, dir_rows[i].tn, dir_rows[i].tv);
        end

        send_cmd(rand_cmd(OP_START), -1, '0);
        while (n_sent < RAND_ITEMS) begin
            if (n_sent >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
            if (!paused && n_sent >= RAND_ITEMS / 2) begin
                // hold the command side until the stream has drained
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) send_cmd(rand_cmd(OP_START), -1, '0);
            else if (pick < 10) send_cmd(rand_cmd(OP_END), -1, '0);
            else if (pick < 50) send_add(1'b0);
            else if (pick < 85) send_copy();
            else if (pick < 92)
                send_cmd(rand_cmd(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI))), -1, '0);
            else if (pick < 96) send_cmd(rand_cmd(OP_ADD_DATA), -1, '0);
            else begin
                send_cmd('{OP_ADD_HDR, 32'($urandom), 32'd0, 8'($urandom)}, -1, '0);
            end
        end
        calm = 1'b1;
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (stream_q.size() != 0) n_err++;

        $display("Summary: %0d commands (%0d with effect), %0d bytes checked, %0d add chunks",
                 n_sent, n_useful, n_bytes, n_chunks);
        $display("Summary: copy opcodes 249..255 seen %0d %0d %0d %0d %0d %0d %0d times",
                 opc_hits[0], opc_hits[1], opc_hits[2], opc_hits[3],
                 opc_hits[4], opc_hits[5], opc_hits[6]);
        if (n_err == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
